// ===== hw/rtl/fgn_pkg.sv =====
package fgn_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int TABLE_W     = 8;
    localparam int TABLE_SIZE  = 1 << TABLE_W;
    localparam int MAX_OCTAVES = 8;
    localparam int COORD_W     = 16;
    localparam int FREQ_W      = 16;
    localparam int OCT_W       = 4;
    localparam int PX_W        = COORD_W + FREQ_W + 1;
    localparam int SX_W        = PX_W + MAX_OCTAVES;
    localparam int DELTA_W     = FRAC_BITS + 2;
    localparam int GRAD_W      = FRAC_BITS + 3;
    localparam int FADE_W      = FRAC_BITS + 1;
    localparam int POLY_W      = FRAC_BITS + 7;
    localparam int OUT_W       = 20;
    localparam int SUM_W       = OUT_W + 3;
    localparam int STAGES      = 10;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 1'd1;
    localparam logic [OCT_W-1:0]  OCTAVE_COUNT_RESET = 4'd4;
    localparam logic [FREQ_W-1:0] BASE_FREQ_RESET    = 16'd3277;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_NOISE = 1'b1;

    typedef struct packed {
        logic               we;
        logic [TABLE_W-1:0] idx;
        logic [TABLE_W-1:0] val;
    } perm_wr_t;

    function automatic logic signed [GRAD_W-1:0] corner_grad(
        input logic [1:0]                h,
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy
    );
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        gx = h[0] ? GRAD_W'(dx) : -GRAD_W'(dx);
        gy = h[1] ? GRAD_W'(dy) : -GRAD_W'(dy);
        return gx + gy;
    endfunction

endpackage

// ===== hw/rtl/fgn_perm_ram.sv =====
module fgn_perm_ram (
    input  logic                    aclk,
    input  logic                    en,
    input  fgn_pkg::perm_wr_t       wr,
    input  logic [fgn_pkg::TABLE_W-1:0] rd_addr_a,
    input  logic [fgn_pkg::TABLE_W-1:0] rd_addr_b,
    output logic [fgn_pkg::TABLE_W-1:0] rd_data_a,
    output logic [fgn_pkg::TABLE_W-1:0] rd_data_b
);
    import fgn_pkg::*;

    logic [TABLE_W-1:0] mem [TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr.we) begin
                mem[wr.idx] <= wr.val;
            end
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end
endmodule

// ===== hw/rtl/fgn_fade.sv =====
module fgn_fade (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [fgn_pkg::FRAC_BITS-1:0] t,
    output logic [fgn_pkg::FADE_W-1:0]    w
);
    import fgn_pkg::*;

    localparam logic [POLY_W-1:0] ONE_FX = POLY_W'(1) << FRAC_BITS;

    logic [FRAC_BITS-1:0] t2_reg, t3_reg, t4_reg;
    logic [FRAC_BITS-1:0] p2_reg, p3_reg, p3d_reg, p3e_reg, p4_reg, p4d_reg, p5_reg;
    logic [FADE_W-1:0]    w_reg;
    logic [2*FRAC_BITS-1:0] m2, m3, m4, m5;
    logic signed [POLY_W-1:0] poly;
    logic [FADE_W-1:0]    w_next;

    assign m2 = t * t;
    assign m3 = p2_reg * t2_reg;
    assign m4 = p3_reg * t3_reg;
    assign m5 = p4_reg * t4_reg;

    always_comb begin
        poly = POLY_W'(10) * $signed(POLY_W'(p3e_reg))
             - POLY_W'(15) * $signed(POLY_W'(p4d_reg))
             + POLY_W'(6)  * $signed(POLY_W'(p5_reg));
        if (poly < 0) begin
            w_next = '0;
        end else if (poly > $signed(ONE_FX)) begin
            w_next = FADE_W'(ONE_FX);
        end else begin
            w_next = FADE_W'(poly);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg  <= t;
            p2_reg  <= m2[2*FRAC_BITS-1:FRAC_BITS];
            t3_reg  <= t2_reg;
            p3_reg  <= m3[2*FRAC_BITS-1:FRAC_BITS];
            t4_reg  <= t3_reg;
            p3d_reg <= p3_reg;
            p4_reg  <= m4[2*FRAC_BITS-1:FRAC_BITS];
            p3e_reg <= p3d_reg;
            p4d_reg <= p4_reg;
            p5_reg  <= m5[2*FRAC_BITS-1:FRAC_BITS];
            w_reg   <= w_next;
        end
    end

    assign w = w_reg;
endmodule

// ===== hw/rtl/fgn_octave.sv =====
module fgn_octave (
    input  logic                          aclk,
    input  logic                          en,
    input  fgn_pkg::perm_wr_t             wr_first,
    input  fgn_pkg::perm_wr_t             wr_second,
    input  logic [fgn_pkg::TABLE_W-1:0]   xi,
    input  logic [fgn_pkg::TABLE_W-1:0]   yi,
    input  logic [fgn_pkg::FRAC_BITS-1:0] fx,
    input  logic [fgn_pkg::FRAC_BITS-1:0] fy,
    output logic signed [fgn_pkg::GRAD_W-1:0] value
);
    import fgn_pkg::*;

    localparam int DIFF_W = GRAD_W + 1;
    localparam int PROD_W = DIFF_W + FADE_W + 1;
    localparam logic signed [DELTA_W-1:0] ONE_D = DELTA_W'(1) << FRAC_BITS;

    logic [TABLE_W-1:0] a0, a1, h00, h01, h10, h11;
    logic [TABLE_W-1:0] yi2_reg;
    logic [FRAC_BITS-1:0] fx2_reg, fy2_reg, fx3_reg, fy3_reg;
    logic [FADE_W-1:0] u, v, v7_reg, v8_reg;
    logic signed [GRAD_W-1:0] g00_reg, g01_reg, g10_reg, g11_reg;
    logic signed [GRAD_W-1:0] g00b_reg, g01b_reg, g10b_reg, g11b_reg;
    logic signed [GRAD_W-1:0] g00c_reg, g01c_reg, g10c_reg, g11c_reg;
    logic signed [GRAD_W-1:0] g00d_reg, g01d_reg;
    logic signed [PROD_W-1:0] pb_reg, pt_reg, pv_reg;
    logic signed [GRAD_W-1:0] bot_reg, top_reg, bot9_reg, val_reg;
    logic signed [DELTA_W-1:0] dx0, dx1, dy0, dy1;
    logic signed [DIFF_W-1:0] db, dt, dv;
    logic signed [PROD_W-1:0] pb_next, pt_next, pv_next;
    logic signed [DIFF_W-1:0] bot_next, top_next, val_next;

    fgn_perm_ram u_first (
        .aclk(aclk), .en(en), .wr(wr_first),
        .rd_addr_a(xi), .rd_addr_b(xi + TABLE_W'(1)),
        .rd_data_a(a0), .rd_data_b(a1)
    );

    fgn_perm_ram u_second_lo (
        .aclk(aclk), .en(en), .wr(wr_second),
        .rd_addr_a(a0 + yi2_reg), .rd_addr_b(a0 + yi2_reg + TABLE_W'(1)),
        .rd_data_a(h00), .rd_data_b(h01)
    );

    fgn_perm_ram u_second_hi (
        .aclk(aclk), .en(en), .wr(wr_second),
        .rd_addr_a(a1 + yi2_reg), .rd_addr_b(a1 + yi2_reg + TABLE_W'(1)),
        .rd_data_a(h10), .rd_data_b(h11)
    );

    fgn_fade u_fade_x (.aclk(aclk), .en(en), .t(fx), .w(u));
    fgn_fade u_fade_y (.aclk(aclk), .en(en), .t(fy), .w(v));

    always_comb begin
        dx0 = $signed(DELTA_W'(fx3_reg));
        dy0 = $signed(DELTA_W'(fy3_reg));
        dx1 = dx0 - ONE_D;
        dy1 = dy0 - ONE_D;
        db  = DIFF_W'(g10c_reg) - DIFF_W'(g00c_reg);
        dt  = DIFF_W'(g11c_reg) - DIFF_W'(g01c_reg);
        pb_next = PROD_W'(db) * $signed(PROD_W'(u));
        pt_next = PROD_W'(dt) * $signed(PROD_W'(u));
        bot_next = DIFF_W'(g00d_reg) + DIFF_W'(pb_reg >>> FRAC_BITS);
        top_next = DIFF_W'(g01d_reg) + DIFF_W'(pt_reg >>> FRAC_BITS);
        dv  = DIFF_W'(top_reg) - DIFF_W'(bot_reg);
        pv_next = PROD_W'(dv) * $signed(PROD_W'(v8_reg));
        val_next = DIFF_W'(bot9_reg) + DIFF_W'(pv_reg >>> FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yi2_reg  <= yi;
            fx2_reg  <= fx;
            fy2_reg  <= fy;
            fx3_reg  <= fx2_reg;
            fy3_reg  <= fy2_reg;
            g00_reg  <= corner_grad(h00[1:0], dx0, dy0);
            g10_reg  <= corner_grad(h10[1:0], dx1, dy0);
            g01_reg  <= corner_grad(h01[1:0], dx0, dy1);
            g11_reg  <= corner_grad(h11[1:0], dx1, dy1);
            g00b_reg <= g00_reg;
            g01b_reg <= g01_reg;
            g10b_reg <= g10_reg;
            g11b_reg <= g11_reg;
            g00c_reg <= g00b_reg;
            g01c_reg <= g01b_reg;
            g10c_reg <= g10b_reg;
            g11c_reg <= g11b_reg;
            pb_reg   <= pb_next;
            pt_reg   <= pt_next;
            g00d_reg <= g00c_reg;
            g01d_reg <= g01c_reg;
            v7_reg   <= v;
            bot_reg  <= GRAD_W'(bot_next);
            top_reg  <= GRAD_W'(top_next);
            v8_reg   <= v7_reg;
            pv_reg   <= pv_next;
            bot9_reg <= bot_reg;
            val_reg  <= GRAD_W'(val_next);
        end
    end

    assign value = val_reg;
endmodule

// ===== hw/rtl/fractal_gradient_noise_2d.sv =====
// Fractal 2D gradient noise. A request with tuser high evaluates noise at integer (x, y)
// and returns one Q3.16 sample; a request with tuser low loads one permutation table entry
// and returns nothing. All eight octaves run side by side in lanes, each with its own
// copies of the table, so one request is taken every clock while m_tready does not stall
// the output; the pipeline depth is set by the chained fade products and the two blend
// multiplies. A table load takes effect for every request that follows it. Every table
// entry must be loaded before noise is requested. Configuration writes are taken at any time
// but should be made only while no request is in flight.
module fractal_gradient_noise_2d (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // table_index, table_value, coord_x, coord_y
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // noise_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [fgn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fgn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fgn_pkg::*;

    logic en;
    logic [OCT_W-1:0]  octave_count_reg;
    logic [FREQ_W-1:0] base_freq_reg;
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] noise_reg;
    logic [TABLE_W-1:0] idx1_reg, val1_reg, idx2_reg, val2_reg;
    logic signed [PX_W-1:0] px_reg, py_reg;
    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_data_reg;
    perm_wr_t wr_first, wr_second;
    logic signed [GRAD_W-1:0] lane_val [MAX_OCTAVES];
    logic [OCT_W:0] n_oct;
    logic signed [SUM_W-1:0] sum;
    logic [OUT_W-1:0] sat;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_count_reg <= OCTAVE_COUNT_RESET;
            base_freq_reg    <= BASE_FREQ_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OCTAVE_COUNT:   octave_count_reg <= cfg_data[OCT_W-1:0];
                REG_BASE_FREQUENCY: base_freq_reg    <= cfg_data[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[STAGES-1:1], s_tvalid};
            m_tvalid_reg <= vld_reg[STAGES] && noise_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            noise_reg  <= {noise_reg[STAGES-1:1], s_tuser[0] == REQ_NOISE};
            idx1_reg   <= s_tdata[7:0];
            val1_reg   <= s_tdata[15:8];
            idx2_reg   <= idx1_reg;
            val2_reg   <= val1_reg;
            px_reg     <= PX_W'($signed(s_tdata[31:16])) * $signed({1'b0, base_freq_reg});
            py_reg     <= PX_W'($signed(s_tdata[47:32])) * $signed({1'b0, base_freq_reg});
            m_data_reg <= sat;
        end
    end

    assign wr_first  = '{we: vld_reg[1] && !noise_reg[1], idx: idx1_reg, val: val1_reg};
    assign wr_second = '{we: vld_reg[2] && !noise_reg[2], idx: idx2_reg, val: val2_reg};

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
        logic [SX_W-1:0] sx, sy;
        assign sx = SX_W'(px_reg) << o;
        assign sy = SX_W'(py_reg) << o;
        fgn_octave u_octave (
            .aclk(aclk), .en(en),
            .wr_first(wr_first), .wr_second(wr_second),
            .xi(sx[FRAC_BITS+TABLE_W-1:FRAC_BITS]),
            .yi(sy[FRAC_BITS+TABLE_W-1:FRAC_BITS]),
            .fx(sx[FRAC_BITS-1:0]),
            .fy(sy[FRAC_BITS-1:0]),
            .value(lane_val[o])
        );
    end

    always_comb begin
        n_oct = (octave_count_reg > OCT_W'(MAX_OCTAVES)) ? (OCT_W+1)'(MAX_OCTAVES)
                                                         : (OCT_W+1)'(octave_count_reg);
        sum = '0;
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            if ((OCT_W+1)'(o) < n_oct) begin
                sum = sum + (SUM_W'(lane_val[o]) >>> o);
            end
        end
        if (sum > $signed(SUM_W'((1 << (OUT_W-1)) - 1))) begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (sum < -$signed(SUM_W'(1 << (OUT_W-1)))) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = sum[OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_data_reg};
endmodule

// ===== hw/rtl/fgn_checker.sv =====
module fgn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        cfg_ready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken during output stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:20] == 4'b0 && cfg_ready)
        else $error("bad result padding");
endmodule

bind fractal_gradient_noise_2d fgn_checker u_fgn_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);
